FILE: rtl/arctangent_series_unit_assert.svh
`ifndef ARCTANGENT_SERIES_UNIT_ASSERT_SVH
`define ARCTANGENT_SERIES_UNIT_ASSERT_SVH

// Checks that a condition implies another in the same cycle.
`define ATS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Checks that a condition implies another in the next cycle.
`define ATS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/ats_pkg.sv
package ats_pkg;

	localparam int WORD_WIDTH = 32;
	localparam int TERMS_WIDTH = 11;
	localparam int MAG_WIDTH = 30;
	localparam int DIVIDEND_WIDTH = 47;
	localparam int QUOT_WIDTH = 31;
	localparam int DIVISOR_WIDTH = 32;

	localparam logic [1:0] CLASS_FINITE = 2'd0;
	localparam logic [1:0] CLASS_PLUS_INF = 2'd1;
	localparam logic [1:0] CLASS_MINUS_INF = 2'd2;
	localparam logic [1:0] CLASS_NAN = 2'd3;

	localparam logic signed [WORD_WIDTH-1:0] PI_HALF_Q28 = 32'sd421657428;
	localparam logic signed [WORD_WIDTH-1:0] PI_QUARTER_Q28 = 32'sd210828714;
	localparam logic [WORD_WIDTH-1:0] ONE_Q16 = 32'h0001_0000;
	localparam logic [TERMS_WIDTH-1:0] TERMS_RESET = 11'd256;

	typedef struct packed {
		logic signed [WORD_WIDTH-1:0] argument;
		logic [1:0] argument_class;
	} arg_t;

	typedef struct packed {
		logic signed [WORD_WIDTH-1:0] angle;
		logic not_a_number;
	} res_t;

	typedef struct packed {
		logic start;
		logic [DIVIDEND_WIDTH-1:0] dividend;
		logic [DIVISOR_WIDTH-1:0] divisor;
	} div_req_t;

endpackage

FILE: rtl/ats_divider.sv
module ats_divider
	import ats_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input div_req_t req,
	output logic done,
	output logic [QUOT_WIDTH-1:0] quotient
);

	logic run_q;
	logic done_q;
	logic [4:0] cnt_q;
	logic [DIVISOR_WIDTH-1:0] rem_q;
	logic [QUOT_WIDTH-1:0] qsh_q;
	logic [DIVISOR_WIDTH-1:0] divisor_q;
	logic [DIVISOR_WIDTH:0] shifted;
	logic [DIVISOR_WIDTH:0] trial;
	logic fits;

	// One restoring step: shift in the next dividend bit and try the subtract.
	always_comb begin
		shifted = {rem_q, qsh_q[QUOT_WIDTH-1]};
		trial = shifted - {1'b0, divisor_q};
		fits = (shifted >= {1'b0, divisor_q});
	end

	// Control of the step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(QUOT_WIDTH - 1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= DIVISOR_WIDTH'(req.dividend >> QUOT_WIDTH);
			qsh_q <= req.dividend[QUOT_WIDTH-1:0];
			divisor_q <= req.divisor;
		end else if (run_q) begin
			rem_q <= fits ? trial[DIVISOR_WIDTH-1:0] : shifted[DIVISOR_WIDTH-1:0];
			qsh_q <= {qsh_q[QUOT_WIDTH-2:0], fits};
		end
	end

	assign done = done_q;
	assign quotient = qsh_q;

endmodule

FILE: rtl/arctangent_series_unit.sv
// Arctangent of a signed Q16.16 argument, result in signed Q3.28.
// Input channel: a transaction is taken when start is high and busy is low;
// operand carries the argument and its class tag.
// Output channel: done is high for one cycle with result; the receiver
// cannot stall it and must take the transaction in that cycle.
// Configuration: cfg_data is written into the term count when cfg_valid and
// cfg_ready are high; cfg_ready is high whenever the block is idle.
// NaN, infinities, zero and +/-1 raise done in the cycle after they are taken.
// A series argument sums its terms one after another, after a reciprocal
// pass of the divider when |x| > 1. Each term is one pass of the
// bit-serial divider (31 steps), with the power update multiplied alongside.
// One transaction is in flight at a time; busy stays high until done.
// Reset clears the sequencer and sets the term count to 256.
module arctangent_series_unit
	import ats_pkg::*;
#(
	parameter int MAX_TERMS = 1024
)(
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input arg_t operand,
	output logic done,
	output res_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [TERMS_WIDTH-1:0] cfg_data
);

	localparam int CW = $clog2(MAX_TERMS + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RECIP = 3'd1;
	localparam logic [2:0] S_SQ = 3'd2;
	localparam logic [2:0] S_SQW = 3'd3;
	localparam logic [2:0] S_TERM = 3'd4;
	localparam logic [2:0] S_DIVW = 3'd5;
	localparam logic [2:0] S_FIN = 3'd6;

	logic [2:0] state_q;
	logic [TERMS_WIDTH-1:0] series_terms_q;
	logic neg_q;
	logic recip_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] i_q;
	logic [MAG_WIDTH-1:0] m_q;
	logic [MAG_WIDTH-1:0] m2_q;
	logic [MAG_WIDTH-1:0] p_q;
	logic [2*MAG_WIDTH-1:0] prod_q;
	logic signed [WORD_WIDTH:0] sum_q;
	logic done_q;
	res_t result_q;

	logic accept;
	logic arg_neg;
	logic [WORD_WIDTH-1:0] mag;
	logic [CW-1:0] terms_clamped;
	logic term_go;
	logic [MAG_WIDTH-1:0] prod_rnd;
	div_req_t div_req;
	logic div_done;
	logic [QUOT_WIDTH-1:0] div_quot;
	logic [WORD_WIDTH:0] sum_abs;
	logic [WORD_WIDTH:0] sum_rnd;
	logic signed [WORD_WIDTH-1:0] r28;
	logic signed [WORD_WIDTH-1:0] r_adj;

	assign accept = start && (state_q == S_IDLE);
	assign busy = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign done = done_q;
	assign result = result_q;

	// Argument magnitude and the clamped term count.
	always_comb begin
		arg_neg = operand.argument[WORD_WIDTH-1];
		mag = arg_neg ? (~operand.argument + 1'b1) : operand.argument;
		if (series_terms_q == '0) begin
			terms_clamped = CW'(1);
		end else if (32'(series_terms_q) > MAX_TERMS) begin
			terms_clamped = CW'(MAX_TERMS);
		end else begin
			terms_clamped = CW'(series_terms_q);
		end
	end

	// Product rounded back to Q0.30.
	always_comb begin
		prod_rnd = MAG_WIDTH'((prod_q + (2*MAG_WIDTH)'(1 << 29)) >> 30);
	end

	// A term is started unless the count is reached or the power vanished.
	assign term_go = (state_q == S_TERM) && (i_q != n_q) && (p_q != '0);

	// Request to the shared divider: reciprocal or one series term.
	always_comb begin
		div_req.start = 1'b0;
		div_req.dividend = '0;
		div_req.divisor = '0;
		if (accept && operand.argument_class == CLASS_FINITE && mag > ONE_Q16) begin
			div_req.start = 1'b1;
			div_req.dividend = (DIVIDEND_WIDTH'(1) << 46) + DIVIDEND_WIDTH'(mag >> 1);
			div_req.divisor = mag;
		end else if (term_go) begin
			div_req.start = 1'b1;
			div_req.dividend = DIVIDEND_WIDTH'(p_q) + DIVIDEND_WIDTH'(i_q);
			div_req.divisor = DIVISOR_WIDTH'({i_q, 1'b1});
		end
	end

	ats_divider u_divider (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.done(div_done),
		.quotient(div_quot)
	);

	// Sum to Q3.28 with halves away from zero, then the final angle.
	always_comb begin
		sum_abs = sum_q[WORD_WIDTH] ? (~sum_q + 1'b1) : sum_q;
		sum_rnd = (sum_abs + (WORD_WIDTH+1)'(2)) >> 2;
		r28 = sum_q[WORD_WIDTH] ? -WORD_WIDTH'(sum_rnd) : WORD_WIDTH'(sum_rnd);
		r_adj = recip_q ? (PI_HALF_Q28 - r28) : r28;
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			series_terms_q <= TERMS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			series_terms_q <= cfg_data;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (operand.argument_class != CLASS_FINITE || mag == '0
							|| mag == ONE_Q16) begin
							done_q <= 1'b1;
						end else if (mag > ONE_Q16) begin
							state_q <= S_RECIP;
						end else begin
							state_q <= S_SQ;
						end
					end
				end
				S_RECIP: begin
					if (div_done) begin
						state_q <= S_SQ;
					end
				end
				S_SQ: state_q <= S_SQW;
				S_SQW: state_q <= S_TERM;
				S_TERM: begin
					state_q <= term_go ? S_DIVW : S_FIN;
				end
				S_DIVW: begin
					if (div_done) begin
						state_q <= S_TERM;
					end
				end
				S_FIN: begin
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					neg_q <= arg_neg;
					recip_q <= (mag > ONE_Q16);
					n_q <= terms_clamped;
					m_q <= {mag[15:0], 14'b0};
					result_q.not_a_number <= 1'b0;
					result_q.angle <= '0;
					if (operand.argument_class == CLASS_NAN) begin
						result_q.not_a_number <= 1'b1;
					end else if (operand.argument_class == CLASS_PLUS_INF) begin
						result_q.angle <= PI_HALF_Q28;
					end else if (operand.argument_class == CLASS_MINUS_INF) begin
						result_q.angle <= -PI_HALF_Q28;
					end else if (mag == ONE_Q16) begin
						result_q.angle <= arg_neg ? -PI_QUARTER_Q28 : PI_QUARTER_Q28;
					end
				end
			end
			S_RECIP: begin
				if (div_done) begin
					m_q <= div_quot[MAG_WIDTH-1:0];
				end
			end
			S_SQ: prod_q <= m_q * m_q;
			S_SQW: begin
				m2_q <= prod_rnd;
				p_q <= m_q;
				i_q <= '0;
				sum_q <= '0;
			end
			S_TERM: prod_q <= p_q * m2_q;
			S_DIVW: begin
				if (div_done) begin
					if (i_q[0]) begin
						sum_q <= sum_q - $signed({2'b0, div_quot});
					end else begin
						sum_q <= sum_q + $signed({2'b0, div_quot});
					end
					p_q <= prod_rnd;
					i_q <= i_q + 1'b1;
				end
			end
			S_FIN: begin
				result_q.angle <= neg_q ? -r_adj : r_adj;
				result_q.not_a_number <= 1'b0;
			end
			default: ;
		endcase
	end

`include "arctangent_series_unit_assert.svh"

	`ATS_ASSERT_NEXT(a_nan_flag, accept && operand.argument_class == CLASS_NAN, done && result.not_a_number, "NaN did not flag")
	`ATS_ASSERT_NOW(a_done_idle, done, !busy, "result while busy")
	`ATS_ASSERT_NOW(a_div_owner, div_done, state_q == S_RECIP || state_q == S_DIVW, "stray divide")

endmodule
